// ===== src/pham_pkg.sv =====
`timescale 1ns / 1ps

package pham_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int COORD_W    = FRAC_BITS + 1;
    localparam int SIZE_W     = 14;
    localparam int PIX_W      = 14;
    localparam int PROD_W     = COORD_W + SIZE_W;
    localparam int RAW_W      = PROD_W - FRAC_BITS;
    localparam int MAX_SIZE   = 8192;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = SIZE_W;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_W = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_H = 1'b1;

    localparam logic [SIZE_W-1:0] SCREEN_W_RESET = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] SCREEN_H_RESET = SIZE_W'(1080);

    localparam logic [COORD_W-1:0] COORD_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_PTR_W = $clog2(OQ_DEPTH);

    typedef enum logic [1:0] {
        HAND_NONE  = 2'd0,
        HAND_LEFT  = 2'd1,
        HAND_RIGHT = 2'd2
    } t_hand;

    typedef enum logic [1:0] {
        KIND_MOVE = 2'd0,
        KIND_DOWN = 2'd1,
        KIND_UP   = 2'd2
    } t_kind;

    typedef struct packed {
        t_hand              hand;
        logic               held_old;
        logic               held_new;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
    } t_job;

    typedef struct packed {
        t_kind            kind;
        logic [PIX_W-1:0] x;
        logic [PIX_W-1:0] y;
        logic             btn;
        t_hand            hand;
        logic             last;
    } t_event;

    typedef struct packed {
        logic valid;
        t_job job;
    } t_jobbeat;

endpackage

// ===== src/pham_front.sv =====
`timescale 1ns / 1ps

module pham_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_accept,
    input  logic [1:0]                      i_plane,
    input  logic [1:0]                      i_on_screen,
    input  logic [1:0]                      i_pressed,
    input  logic [1:0][pham_pkg::COORD_W-1:0] i_u,
    input  logic [1:0][pham_pkg::COORD_W-1:0] i_v,
    output pham_pkg::t_jobbeat              o_beat
);
    import pham_pkg::*;

    t_hand      r_active, n_active;
    logic       r_held, n_held;
    logic [1:0] scr;
    logic       act_ok;
    logic       aidx;
    logic       hidx;
    t_hand      hand;

    function automatic logic [COORD_W-1:0] sat_coord(input logic [COORD_W-1:0] c);
        return (c > COORD_ONE) ? COORD_ONE : c;
    endfunction

    assign scr    = i_plane & i_on_screen;
    assign act_ok = (r_active == HAND_LEFT) || (r_active == HAND_RIGHT);
    assign aidx   = (r_active == HAND_RIGHT);

    always_comb begin
        if (r_held && act_ok && i_plane[aidx]) begin
            hand = r_active;
        end else if (scr[0] && i_pressed[0]) begin
            hand = HAND_LEFT;
        end else if (scr[1] && i_pressed[1]) begin
            hand = HAND_RIGHT;
        end else if (act_ok && scr[aidx]) begin
            hand = r_active;
        end else if (scr[0]) begin
            hand = HAND_LEFT;
        end else if (scr[1]) begin
            hand = HAND_RIGHT;
        end else begin
            hand = HAND_NONE;
        end
    end

    assign hidx     = (hand == HAND_RIGHT);
    assign n_active = hand;
    assign n_held   = (hand != HAND_NONE) && i_pressed[hidx];

    always_comb begin
        o_beat.valid        = i_accept;
        o_beat.job.hand     = hand;
        o_beat.job.held_old = r_held;
        o_beat.job.held_new = n_held;
        o_beat.job.u        = sat_coord(i_u[hidx]);
        o_beat.job.v        = sat_coord(i_v[hidx]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= HAND_NONE;
            r_held   <= 1'b0;
        end else if (i_accept) begin
            r_active <= n_active;
            r_held   <= n_held;
        end
    end

endmodule

// ===== src/pham_queue.sv =====
`timescale 1ns / 1ps

module pham_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pham_pkg::t_jobbeat i_beat,
    output logic               o_full,
    input  logic               i_rd,
    output pham_pkg::t_jobbeat o_beat
);
    import pham_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, r_rp;
    logic [QPTR_W:0]   r_cnt;
    logic              wr, rd;

    assign o_full = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign wr     = i_beat.valid && !o_full;
    assign rd     = i_rd && (r_cnt != '0);

    always_comb begin
        o_beat.valid = (r_cnt != '0);
        o_beat.job   = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wp] <= i_beat.job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr) begin
                r_wp <= r_wp + QPTR_W'(1);
            end
            if (rd) begin
                r_rp <= r_rp + QPTR_W'(1);
            end
            r_cnt <= r_cnt + (QPTR_W+1)'(wr) - (QPTR_W+1)'(rd);
        end
    end

endmodule

// ===== src/pham_back.sv =====
`timescale 1ns / 1ps

module pham_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [pham_pkg::SIZE_W-1:0]  i_screen_w,
    input  logic [pham_pkg::SIZE_W-1:0]  i_screen_h,
    input  pham_pkg::t_jobbeat           i_beat,
    output logic                         o_rd,
    input  logic                         i_pop,
    output logic                         o_empty,
    output pham_pkg::t_event             o_head
);
    import pham_pkg::*;

    // multiply stage
    logic              r_a_valid;
    t_hand             r_a_hand;
    logic              r_a_held_old, r_a_held_new;
    logic [PROD_W-1:0] r_a_prod_x, r_a_prod_y;
    logic [SIZE_W-1:0] r_a_sw, r_a_sh;

    logic [PIX_W-1:0]  r_last_x, r_last_y;

    t_event              r_omem [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] r_owp, r_orp;
    logic [OQ_PTR_W:0]   r_ocnt;

    logic [SIZE_W-1:0] sw, sh;
    logic              a_take, a_load, opop;
    logic [SIZE_W-1:0] lim_x, lim_y;
    logic [RAW_W-1:0]  raw_x, raw_y;
    logic [PIX_W-1:0]  px, py, ev_x, ev_y;
    logic              has_hand, do_move, do_btn;
    t_event            ev_move, ev_btn, ev_first;
    logic [1:0]        nwr;

    function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
        if (s == '0) begin
            return SIZE_W'(1);
        end else if (s > SIZE_W'(MAX_SIZE)) begin
            return SIZE_W'(MAX_SIZE);
        end else begin
            return s;
        end
    endfunction

    assign sw = eff_size(i_screen_w);
    assign sh = eff_size(i_screen_h);

    assign a_take = r_a_valid && (r_ocnt <= (OQ_PTR_W+1)'(OQ_DEPTH - 2));
    assign a_load = i_beat.valid && (!r_a_valid || a_take);
    assign o_rd   = a_load;
    assign opop   = i_pop && (r_ocnt != '0);

    always_ff @(posedge i_clk) begin
        if (a_load) begin
            r_a_hand     <= i_beat.job.hand;
            r_a_held_old <= i_beat.job.held_old;
            r_a_held_new <= i_beat.job.held_new;
            r_a_prod_x   <= PROD_W'(i_beat.job.u) * PROD_W'(sw);
            r_a_prod_y   <= PROD_W'(i_beat.job.v) * PROD_W'(sh);
            r_a_sw       <= sw;
            r_a_sh       <= sh;
        end
    end

    always_comb begin
        lim_x = r_a_sw - SIZE_W'(1);
        lim_y = r_a_sh - SIZE_W'(1);
        raw_x = r_a_prod_x[PROD_W-1:FRAC_BITS];
        raw_y = r_a_prod_y[PROD_W-1:FRAC_BITS];
        px = (raw_x > RAW_W'(lim_x)) ? PIX_W'(lim_x) : raw_x[PIX_W-1:0];
        py = (raw_y > RAW_W'(lim_y)) ? PIX_W'(lim_y) : raw_y[PIX_W-1:0];

        has_hand = (r_a_hand != HAND_NONE);
        do_move  = has_hand && ((px != r_last_x) || (py != r_last_y));
        do_btn   = (r_a_held_old != r_a_held_new);
        ev_x     = has_hand ? px : r_last_x;
        ev_y     = has_hand ? py : r_last_y;

        ev_move.kind = KIND_MOVE;
        ev_move.x    = px;
        ev_move.y    = py;
        ev_move.btn  = r_a_held_old;
        ev_move.hand = r_a_hand;
        ev_move.last = !do_btn;

        ev_btn.kind  = r_a_held_new ? KIND_DOWN : KIND_UP;
        ev_btn.x     = ev_x;
        ev_btn.y     = ev_y;
        ev_btn.btn   = r_a_held_new;
        ev_btn.hand  = r_a_hand;
        ev_btn.last  = 1'b1;

        ev_first = do_move ? ev_move : ev_btn;
        nwr      = 2'(do_move) + 2'(do_btn);
    end

    always_ff @(posedge i_clk) begin
        if (a_take && (nwr != 2'd0)) begin
            r_omem[r_owp] <= ev_first;
        end
        if (a_take && (nwr == 2'd2)) begin
            r_omem[r_owp + OQ_PTR_W'(1)] <= ev_btn;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_last_x  <= '1;
            r_last_y  <= '1;
            r_owp     <= '0;
            r_orp     <= '0;
            r_ocnt    <= '0;
        end else begin
            if (a_load) begin
                r_a_valid <= 1'b1;
            end else if (a_take) begin
                r_a_valid <= 1'b0;
            end
            if (a_take && do_move) begin
                r_last_x <= px;
                r_last_y <= py;
            end
            if (a_take) begin
                r_owp <= r_owp + OQ_PTR_W'(nwr);
            end
            if (opop) begin
                r_orp <= r_orp + OQ_PTR_W'(1);
            end
            r_ocnt <= r_ocnt + (a_take ? (OQ_PTR_W+1)'(nwr) : '0)
                      - (OQ_PTR_W+1)'(opop);
        end
    end

    assign o_empty = (r_ocnt == '0);
    assign o_head  = r_omem[r_orp];

endmodule

// ===== src/pointer_hand_arbiter_mouse_events.sv =====
`timescale 1ns / 1ps

// Pointer hand arbiter: one frame of traced pointer state per push, zero to two
// mouse events out per frame. The front picks the hand and updates hand and
// button state in the accept cycle; a four-entry job queue feeds the back,
// which multiplies the coordinates by the screen size in one stage and then
// quantizes, compares with the last pixel and writes the events to a
// four-entry result queue. A push is taken every cycle while the job queue
// has room; a frame's events pass the job queue and the multiply stage before
// they reach the result side. Sustained rate is one frame per cycle when each
// frame gives at most one event, and one event per cycle overall, set by the
// single-beat pop side. Screen size registers are written through the plain
// write port by the user only while idle; the block does not enforce it.

module pointer_hand_arbiter_mouse_events (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pham_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [pham_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic                               i_left_on_plane,
    input  logic                               i_left_on_screen,
    input  logic                               i_left_pressed,
    input  logic [pham_pkg::COORD_W-1:0]       i_left_u,
    input  logic [pham_pkg::COORD_W-1:0]       i_left_v,
    input  logic                               i_right_on_plane,
    input  logic                               i_right_on_screen,
    input  logic                               i_right_pressed,
    input  logic [pham_pkg::COORD_W-1:0]       i_right_u,
    input  logic [pham_pkg::COORD_W-1:0]       i_right_v,
    output logic                               empty,
    input  logic                               pop,
    output logic [1:0]                         o_event_kind,
    output logic signed [pham_pkg::PIX_W-1:0]  o_pixel_x,
    output logic signed [pham_pkg::PIX_W-1:0]  o_pixel_y,
    output logic                               o_button_state,
    output logic [1:0]                         o_active_hand_out,
    output logic                               o_last_event
);
    import pham_pkg::*;

    logic [SIZE_W-1:0] r_screen_w, r_screen_h;
    t_jobbeat          front_beat, queue_beat;
    logic              q_full, q_rd, accept;
    t_event            head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RESET;
            r_screen_h <= SCREEN_H_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SCREEN_W: r_screen_w <= i_cfg_data;
                REG_SCREEN_H: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign full   = q_full;
    assign accept = push && !q_full;

    pham_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_plane     ({i_right_on_plane, i_left_on_plane}),
        .i_on_screen ({i_right_on_screen, i_left_on_screen}),
        .i_pressed   ({i_right_pressed, i_left_pressed}),
        .i_u         ({i_right_u, i_left_u}),
        .i_v         ({i_right_v, i_left_v}),
        .o_beat      (front_beat)
    );

    pham_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_beat  (front_beat),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_beat  (queue_beat)
    );

    pham_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_screen_w (r_screen_w),
        .i_screen_h (r_screen_h),
        .i_beat     (queue_beat),
        .o_rd       (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_head     (head)
    );

    assign o_event_kind      = head.kind;
    assign o_pixel_x         = $signed(head.x);
    assign o_pixel_y         = $signed(head.y);
    assign o_button_state    = head.btn;
    assign o_active_hand_out = head.hand;
    assign o_last_event      = head.last;

    a_move_has_hand: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_event_kind == KIND_MOVE)) |-> (o_active_hand_out != HAND_NONE))
        else $error("move beat without an active hand");

    a_no_hand_is_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_active_hand_out == HAND_NONE))
        |-> ((o_event_kind == KIND_UP) && !o_button_state && o_last_event))
        else $error("handless beat is not a final release");

    a_hand_pixel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_active_hand_out != HAND_NONE)) |-> !o_pixel_x[PIX_W-1])
        else $error("active hand beat at negative pixel");

    a_down_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && (o_event_kind == KIND_DOWN)) |-> (o_button_state && o_last_event))
        else $error("button down beat with button not held");

endmodule

// ===== dv/pointer_hand_arbiter_mouse_events_tb.sv =====
`timescale 1ns / 1ps

module pointer_hand_arbiter_mouse_events_tb;

    import pham_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_FRAMES = 158;
    localparam int SETTLE_CYC   = 8;

    typedef struct packed {
        logic               on_plane;
        logic               on_screen;
        logic               pressed;
        logic [COORD_W-1:0] u;
        logic [COORD_W-1:0] v;
    } t_ptr;

    typedef struct packed {
        t_ptr lh;
        t_ptr rh;
    } t_frame;

    class pointer_cursor;
        logic [SIZE_W-1:0] screen_w = SCREEN_W_RESET;
        logic [SIZE_W-1:0] screen_h = SCREEN_H_RESET;
        t_hand             hand     = HAND_NONE;
        bit                held     = 1'b0;
        logic [PIX_W-1:0]  last_x   = '1;
        logic [PIX_W-1:0]  last_y   = '1;
        t_event            events_due[$];
        int                errors   = 0;

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            if (idx == REG_SCREEN_W) screen_w = d;
            else if (idx == REG_SCREEN_H) screen_h = d;
        endfunction

        function logic [PIX_W-1:0] quantize(logic [COORD_W-1:0] c, logic [SIZE_W-1:0] sz_reg);
            longint unsigned sz, cc, p;
            sz = (sz_reg == '0) ? 64'd1 :
                 ((sz_reg > SIZE_W'(MAX_SIZE)) ? 64'(MAX_SIZE) : 64'(sz_reg));
            cc = 64'(c);
            if (cc > (64'd1 << FRAC_BITS)) cc = 64'd1 << FRAC_BITS;
            p = (cc * sz) >> FRAC_BITS;
            if (p > sz - 1) p = sz - 1;
            return PIX_W'(p);
        endfunction

        function void add_event(t_kind kind, logic [PIX_W-1:0] x, logic [PIX_W-1:0] y);
            t_event ev;
            ev.kind = kind;
            ev.x    = x;
            ev.y    = y;
            ev.btn  = held;
            ev.hand = hand;
            ev.last = 1'b0;
            events_due.push_back(ev);
        endfunction

        function void note_frame(t_frame f);
            t_ptr             p[2];
            bit               scr[2];
            t_hand            pick;
            int               n0;
            int               h;
            logic [PIX_W-1:0] px, py;
            p[0] = f.lh;
            p[1] = f.rh;
            for (int i = 0; i < 2; i++) scr[i] = p[i].on_plane && p[i].on_screen;
            pick = HAND_NONE;
            if (held && hand != HAND_NONE && p[int'(hand) - 1].on_plane) begin
                pick = hand;
            end else begin
                for (int i = 0; i < 2; i++)
                    if (pick == HAND_NONE && scr[i] && p[i].pressed) pick = t_hand'(i + 1);
                if (pick == HAND_NONE && hand != HAND_NONE && scr[int'(hand) - 1])
                    pick = hand;
                for (int i = 0; i < 2; i++)
                    if (pick == HAND_NONE && scr[i]) pick = t_hand'(i + 1);
            end
            hand = pick;
            n0 = events_due.size();
            if (hand == HAND_NONE) begin
                if (held) begin
                    held = 1'b0;
                    add_event(KIND_UP, last_x, last_y);
                end
            end else begin
                h  = int'(hand) - 1;
                px = quantize(p[h].u, screen_w);
                py = quantize(p[h].v, screen_h);
                if (px != last_x || py != last_y) begin
                    last_x = px;
                    last_y = py;
                    add_event(KIND_MOVE, px, py);
                end
                if (p[h].pressed != held) begin
                    held = p[h].pressed;
                    add_event(held ? KIND_DOWN : KIND_UP, px, py);
                end
            end
            if (events_due.size() > n0) events_due[$].last = 1'b1;
        endfunction

        function void check_event(t_event got);
            t_event want;
            if (events_due.size() == 0) begin
                $error("unexpected event: kind %0d x %0d y %0d", got.kind,
                       $signed(got.x), $signed(got.y));
                errors++;
                return;
            end
            want = events_due.pop_front();
            if (got.kind !== want.kind) begin
                $error("event_kind: expected %0d, actual %0d", want.kind, got.kind);
                errors++;
            end
            if (got.x !== want.x) begin
                $error("pixel_x: expected %0d, actual %0d", $signed(want.x), $signed(got.x));
                errors++;
            end
            if (got.y !== want.y) begin
                $error("pixel_y: expected %0d, actual %0d", $signed(want.y), $signed(got.y));
                errors++;
            end
            if (got.btn !== want.btn) begin
                $error("button_state: expected %0d, actual %0d", want.btn, got.btn);
                errors++;
            end
            if (got.hand !== want.hand) begin
                $error("active_hand_out: expected %0d, actual %0d", want.hand, got.hand);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last_event: expected %0d, actual %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic                            i_clk             = 1'b0;
    logic                            i_rst_n           = 1'b0;
    logic                            i_cfg_we          = 1'b0;
    logic [CFG_IDX_W-1:0]            i_cfg_idx         = '0;
    logic [CFG_DATA_W-1:0]           i_cfg_data        = '0;
    logic                            push              = 1'b0;
    logic                            full;
    logic                            i_left_on_plane   = 1'b0;
    logic                            i_left_on_screen  = 1'b0;
    logic                            i_left_pressed    = 1'b0;
    logic [COORD_W-1:0]              i_left_u          = '0;
    logic [COORD_W-1:0]              i_left_v          = '0;
    logic                            i_right_on_plane  = 1'b0;
    logic                            i_right_on_screen = 1'b0;
    logic                            i_right_pressed   = 1'b0;
    logic [COORD_W-1:0]              i_right_u         = '0;
    logic [COORD_W-1:0]              i_right_v         = '0;
    logic                            empty;
    logic                            pop               = 1'b0;
    logic [1:0]                      o_event_kind;
    logic signed [PIX_W-1:0]         o_pixel_x;
    logic signed [PIX_W-1:0]         o_pixel_y;
    logic                            o_button_state;
    logic [1:0]                      o_active_hand_out;
    logic                            o_last_event;

    pointer_cursor cursor = new();
    int            cycles = 0;
    int            send_calm = 0;
    int            pop_stall = 0;
    int            pop_calm = 0;
    t_frame        scene = '0;

    pointer_hand_arbiter_mouse_events u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .push              (push),
        .full              (full),
        .i_left_on_plane   (i_left_on_plane),
        .i_left_on_screen  (i_left_on_screen),
        .i_left_pressed    (i_left_pressed),
        .i_left_u          (i_left_u),
        .i_left_v          (i_left_v),
        .i_right_on_plane  (i_right_on_plane),
        .i_right_on_screen (i_right_on_screen),
        .i_right_pressed   (i_right_pressed),
        .i_right_u         (i_right_u),
        .i_right_v         (i_right_v),
        .empty             (empty),
        .pop               (pop),
        .o_event_kind      (o_event_kind),
        .o_pixel_x         (o_pixel_x),
        .o_pixel_y         (o_pixel_y),
        .o_button_state    (o_button_state),
        .o_active_hand_out (o_active_hand_out),
        .o_last_event      (o_last_event)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // event side: check beat, then plan the next pop with random stalls
    always @(posedge i_clk) begin : event_side
        t_event got;
        int     r;
        if (i_rst_n && pop && !empty) begin
            got.kind = t_kind'(o_event_kind);
            got.x    = o_pixel_x;
            got.y    = o_pixel_y;
            got.btn  = o_button_state;
            got.hand = t_hand'(o_active_hand_out);
            got.last = o_last_event;
            cursor.check_event(got);
        end
        if (pop_stall > 0) begin
            pop <= 1'b0;
            pop_stall <= pop_stall - 1;
        end else begin
            pop <= 1'b1;
            r = $urandom_range(0, 99);
            if (pop_calm > 0) begin
                pop_calm <= pop_calm - 1;
            end else if (r < 20) begin
                pop_stall <= $urandom_range(1, 3);
            end else if (r < 23) begin
                pop_stall <= $urandom_range(10, 40);
            end else if (r < 26) begin
                pop_calm <= $urandom_range(30, 80);
            end
        end
    end

    function automatic t_ptr mk_ptr(bit pl, bit sc, bit pr, int u, int v);
        t_ptr p;
        p.on_plane  = pl;
        p.on_screen = sc;
        p.pressed   = pr;
        p.u         = COORD_W'(u);
        p.v         = COORD_W'(v);
        return p;
    endfunction

    function automatic logic [COORD_W-1:0] coord_move(logic [COORD_W-1:0] c);
        int r;
        int n;
        r = $urandom_range(0, 15);
        if (r < 8) return c;
        if (r < 12) begin
            n = int'(c) + $urandom_range(0, 256) - 128;
            if (n < 0) n = 0;
            if (n > 65536) n = 65536;
            return COORD_W'(n);
        end
        if (r < 14) return COORD_W'($urandom_range(0, 65536));
        if (r == 14) return $urandom_range(0, 1) ? COORD_ONE : '0;
        return COORD_W'($urandom_range(65537, 131071));
    endfunction

    function automatic t_ptr drift(t_ptr p);
        if ($urandom_range(0, 7) == 0) p.on_plane = ~p.on_plane;
        if ($urandom_range(0, 5) == 0) p.on_screen = ~p.on_screen;
        if ($urandom_range(0, 4) == 0) p.pressed = ~p.pressed;
        p.u = coord_move(p.u);
        p.v = coord_move(p.v);
        return p;
    endfunction

    function automatic t_ptr noise_ptr();
        return mk_ptr(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)),
                      $urandom_range(0, 131071), $urandom_range(0, 131071));
    endfunction

    function automatic int gap_len();
        int r;
        if (send_calm > 0) begin
            send_calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 5) send_calm = $urandom_range(20, 60);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic push_frame(t_frame f);
        i_left_on_plane   <= f.lh.on_plane;
        i_left_on_screen  <= f.lh.on_screen;
        i_left_pressed    <= f.lh.pressed;
        i_left_u          <= f.lh.u;
        i_left_v          <= f.lh.v;
        i_right_on_plane  <= f.rh.on_plane;
        i_right_on_screen <= f.rh.on_screen;
        i_right_pressed   <= f.rh.pressed;
        i_right_u         <= f.rh.u;
        i_right_v         <= f.rh.v;
        push              <= 1'b1;
        do @(posedge i_clk); while (full);
        cursor.note_frame(f);
    endtask

    task automatic push_with_gap(t_frame f);
        int g;
        push_frame(f);
        g = gap_len();
        if (g > 0) begin
            push <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        push <= 1'b0;
        while (cursor.events_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_sizes(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_SCREEN_W;
        i_cfg_data <= w;
        @(posedge i_clk);
        cursor.set_reg(REG_SCREEN_W, w);
        i_cfg_idx  <= REG_SCREEN_H;
        i_cfg_data <= h;
        @(posedge i_clk);
        cursor.set_reg(REG_SCREEN_H, h);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        t_frame            dir[$];
        t_frame            f;
        logic [SIZE_W-1:0] widths[6];
        logic [SIZE_W-1:0] heights[6];

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // idle frame, on screen without plane, plain move
        dir.push_back({mk_ptr(0, 0, 0, 0, 0), mk_ptr(0, 0, 0, 0, 0)});
        dir.push_back({mk_ptr(0, 1, 1, 100, 100), mk_ptr(0, 1, 1, 200, 200)});
        dir.push_back({mk_ptr(1, 1, 0, 0, 0), mk_ptr(0, 0, 0, 0, 0)});
        dir.push_back({mk_ptr(1, 1, 0, 0, 0), mk_ptr(0, 0, 0, 0, 0)});
        // press, then drag off screen but on plane
        dir.push_back({mk_ptr(1, 1, 1, 0, 0), mk_ptr(0, 0, 0, 0, 0)});
        dir.push_back({mk_ptr(1, 0, 1, 65536, 65536), mk_ptr(0, 0, 0, 0, 0)});
        // drag holds against a pressed right hand; coordinate above one
        dir.push_back({mk_ptr(1, 1, 1, 131071, 131071), mk_ptr(1, 1, 1, 5, 5)});
        dir.push_back({mk_ptr(1, 1, 0, 32768, 32768), mk_ptr(1, 1, 0, 1000, 2000)});
        dir.push_back({mk_ptr(1, 1, 0, 32768, 32768), mk_ptr(1, 1, 0, 3000, 4000)});
        // pressed hand wins
        dir.push_back({mk_ptr(1, 1, 0, 32768, 32768), mk_ptr(1, 1, 1, 131071, 0)});
        // right leaves plane while held: left takes over and releases
        dir.push_back({mk_ptr(1, 1, 0, 65535, 1), mk_ptr(0, 1, 1, 65536, 0)});
        dir.push_back({mk_ptr(1, 1, 1, 65535, 1), mk_ptr(0, 0, 0, 0, 0)});
        // release with no hand at last pixel
        dir.push_back({mk_ptr(0, 1, 1, 9, 9), mk_ptr(0, 0, 0, 0, 0)});
        dir.push_back({mk_ptr(1, 1, 0, 40000, 20000), mk_ptr(1, 1, 0, 100, 100)});
        dir.push_back({mk_ptr(0, 0, 0, 0, 0), mk_ptr(1, 1, 0, 65536, 65536)});
        // previous hand kept over left
        dir.push_back({mk_ptr(1, 1, 0, 1, 1), mk_ptr(1, 1, 0, 65536, 65536)});
        dir.push_back({mk_ptr(1, 1, 0, 1, 1), mk_ptr(1, 1, 1, 98303, 65537)});
        dir.push_back({mk_ptr(1, 0, 1, 0, 0), mk_ptr(0, 0, 1, 0, 0)});
        dir.push_back({mk_ptr(1, 1, 1, 65536, 0), mk_ptr(1, 1, 1, 0, 65536)});
        dir.push_back({mk_ptr(1, 1, 1, 65536, 0), mk_ptr(1, 1, 1, 0, 65536)});
        dir.push_back({mk_ptr(0, 0, 0, 0, 0), mk_ptr(1, 1, 1, 0, 65536)});
        foreach (dir[i]) push_with_gap(dir[i]);
        settle();

        widths  = '{SCREEN_W_RESET, 1, 8192, 0, 16383, 0};
        heights = '{SCREEN_H_RESET, 1, 8192, 16383, 0, 0};
        widths[5]  = SIZE_W'($urandom_range(1, 4096));
        heights[5] = SIZE_W'($urandom_range(1, 4096));

        for (int ph = 0; ph < 6; ph++) begin
            if (ph > 0) write_sizes(widths[ph], heights[ph]);
            for (int n = 0; n < PHASE_FRAMES; n++) begin
                if ($urandom_range(0, 9) == 0) begin
                    f = {noise_ptr(), noise_ptr()};
                end else begin
                    scene.lh = drift(scene.lh);
                    scene.rh = drift(scene.rh);
                    f = scene;
                end
                push_with_gap(f);
                if (n == PHASE_FRAMES / 2) drain();
            end
            settle();
        end

        if (cursor.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
